/* sv/sspst_pkg.sv */
`timescale 1ns / 1ps

package sspst_pkg;

  localparam int SAMPLE_W = 32;
  localparam int SAMPLE_COUNT_W = 6;

  // p95 index = floor(x * 95 / 100), division done as multiply by 2^19/100 and shift
  localparam int P95_NUM = 95;
  localparam int P95_MUL_W = 7;
  localparam int RECIP = 5243;
  localparam int RECIP_W = 13;
  localparam int RECIP_SHIFT = 19;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_value;
    logic                is_last;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]       min_value;
    logic [SAMPLE_W-1:0]       median_value;
    logic [SAMPLE_W-1:0]       p95_value;
    logic [SAMPLE_W-1:0]       max_value;
    logic [SAMPLE_COUNT_W-1:0] sample_count;
    logic                      overflowed;
  } out_t;

endpackage

/* sv/sorted_sample_percentile_stats_top.sv */
`timescale 1ns / 1ps

// Collects unsigned 32-bit samples into a sorted store of MAX_SAMPLES entries held in one
// single-port-write, one-read memory, and on the sample flagged is_last returns min, upper
// median (index n/2), 95th percentile (index floor((n-1)*95/100)), max, the count and an
// overflow flag, then starts a new set. Insertion walks the store from the top, one memory
// read and one write per cycle, moving larger entries up one place. A sample into an empty
// store is written at once; one that meets a full store is dropped and sets the flag.
// A closing sample then reads the four statistics through the one read port, and waits there
// while a previous result is still stalled. in_stall is high while a sample is in work.
module sorted_sample_percentile_stats_top import sspst_pkg::*; #(
  parameter int MAX_SAMPLES = 32
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int PW = CW + P95_MUL_W;
  localparam int QW = PW + RECIP_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SHIFT = 4'b0010,
    ST_PLACE = 4'b0100,
    ST_STAT  = 4'b1000
  } state_t;

  typedef enum logic [4:0] {
    SP_START = 5'b00001,
    SP_MIN   = 5'b00010,
    SP_MED   = 5'b00100,
    SP_P95   = 5'b01000,
    SP_MAX   = 5'b10000
  } step_t;

  state_t              state_r, state_nxt;
  step_t               step_r, step_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                ovf_r, ovf_nxt;
  logic [SAMPLE_W-1:0] v_r, v_nxt;
  logic                last_r, last_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [PW-1:0]       prod_r, prod_nxt;
  logic [AW-1:0]       idx_r, idx_nxt;
  out_t                res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  out_t                out_data_r, out_data_nxt;

  logic [SAMPLE_W-1:0] mem [MAX_SAMPLES];
  logic [SAMPLE_W-1:0] rd_data_r;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  logic [AW-1:0]       wr_addr;
  logic [SAMPLE_W-1:0] wr_data;
  logic                in_xfer;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    v_nxt         = v_r;
    last_nxt      = last_r;
    pos_nxt       = pos_r;
    prod_nxt      = prod_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    rd_addr       = AW'(count_r - CW'(1));
    wr_en         = 1'b0;
    wr_addr       = pos_r + AW'(1);
    wr_data       = v_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          v_nxt    = in_data.sample_value;
          last_nxt = in_data.is_last;
          step_nxt = SP_START;
          if (count_r == CW'(MAX_SAMPLES)) begin
            ovf_nxt = 1'b1;
            if (in_data.is_last) begin
              state_nxt = ST_STAT;
            end
          end else if (count_r == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = in_data.sample_value;
            count_nxt = count_r + CW'(1);
            if (in_data.is_last) begin
              state_nxt = ST_STAT;
            end
          end else begin
            pos_nxt   = AW'(count_r - CW'(1));
            state_nxt = ST_SHIFT;
          end
        end
      end
      ST_SHIFT: begin
        rd_addr = pos_r - AW'(1);
        wr_en   = 1'b1;
        wr_addr = pos_r + AW'(1);
        if (rd_data_r > v_r) begin
          wr_data = rd_data_r;
          if (pos_r == '0) begin
            state_nxt = ST_PLACE;
          end else begin
            pos_nxt = pos_r - AW'(1);
          end
        end else begin
          wr_data   = v_r;
          count_nxt = count_r + CW'(1);
          state_nxt = last_r ? ST_STAT : ST_IDLE;
        end
      end
      ST_PLACE: begin
        wr_en     = 1'b1;
        wr_addr   = '0;
        wr_data   = v_r;
        count_nxt = count_r + CW'(1);
        state_nxt = last_r ? ST_STAT : ST_IDLE;
      end
      ST_STAT: begin
        case (step_r)
          SP_START: begin
            rd_addr  = '0;
            prod_nxt = PW'(count_r - CW'(1)) * PW'(P95_NUM);
            step_nxt = SP_MIN;
          end
          SP_MIN: begin
            res_nxt.min_value = rd_data_r;
            rd_addr  = AW'(count_r >> 1);
            idx_nxt  = AW'((QW'(prod_r) * QW'(RECIP)) >> RECIP_SHIFT);
            step_nxt = SP_MED;
          end
          SP_MED: begin
            res_nxt.median_value = rd_data_r;
            rd_addr  = idx_r;
            step_nxt = SP_P95;
          end
          SP_P95: begin
            res_nxt.p95_value = rd_data_r;
            step_nxt = SP_MAX;
          end
          SP_MAX: begin
            if (!out_valid_r || !out_stall) begin
              out_valid_nxt             = 1'b1;
              out_data_nxt              = res_r;
              out_data_nxt.max_value    = rd_data_r;
              out_data_nxt.sample_count = SAMPLE_COUNT_W'(count_r);
              out_data_nxt.overflowed   = ovf_r;
              count_nxt                 = '0;
              ovf_nxt                   = 1'b0;
              state_nxt                 = ST_IDLE;
            end
          end
          default: begin
            step_nxt = SP_START;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= SP_START;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r        <= v_nxt;
    last_r     <= last_nxt;
    pos_r      <= pos_nxt;
    prod_r     <= prod_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  // sorted store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

/* sv/sspst_checker.sv */
`timescale 1ns / 1ps

module sspst_checker import sspst_pkg::*; #(
  parameter int MAX_SAMPLES = 32
) (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // a stalled sample holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled sample changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // statistics come from a sorted set
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.min_value <= out_data.median_value &&
                  out_data.min_value <= out_data.p95_value &&
                  out_data.median_value <= out_data.max_value &&
                  out_data.p95_value <= out_data.max_value)
    else $error("result statistics out of order");

  // a closed set is never empty
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (MAX_SAMPLES >= 64) || (out_data.sample_count != '0))
    else $error("result with zero samples");

  // dropping only happens with a full store
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.overflowed |->
      out_data.sample_count == SAMPLE_COUNT_W'(MAX_SAMPLES))
    else $error("overflow flagged without full store");

endmodule

bind sorted_sample_percentile_stats_top sspst_checker #(
  .MAX_SAMPLES(MAX_SAMPLES)
) u_sspst_checker (.*);

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import sspst_pkg::*;

  localparam int MAX_KEPT = 32;
  localparam int RANDOM_SAMPLES = 1800;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    bit                  last;
    int                  reps;
    bit                  typed;
    out_t                want;
  } plan_row_t;

  localparam int PLAN_ROWS = 13;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  logic [SAMPLE_W-1:0] kept [MAX_KEPT];
  int   kept_n = 0;
  bit   dropped = 1'b0;
  out_t stats_q [$];

  bit quiet = 1'b0;
  bit squeeze_req = 1'b0;
  int fails = 0;
  int samples_sent = 0;
  int sets_closed = 0;
  int overflow_sets = 0;
  int results_seen = 0;

  // single-item sets, small mixed sets, equal samples, full store, dropped closing sample
  plan_row_t plan [PLAN_ROWS] = '{
    '{32'h0000_0000, 1'b1, 1,  1'b1, '{32'h0, 32'h0, 32'h0, 32'h0, 6'd1, 1'b0}},
    '{32'hFFFF_FFFF, 1'b1, 1,  1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd1, 1'b0}},
    '{32'h0000_0007, 1'b0, 1,  1'b0, '0},
    '{32'h0000_0001, 1'b1, 1,  1'b1, '{32'h1, 32'h7, 32'h1, 32'h7, 6'd2, 1'b0}},
    '{32'h8000_0000, 1'b0, 1,  1'b0, '0},
    '{32'hFFFF_FFFF, 1'b0, 1,  1'b0, '0},
    '{32'h0000_0000, 1'b0, 1,  1'b0, '0},
    '{32'h7FFF_FFFF, 1'b1, 1,  1'b0, '0},
    '{32'h1234_5678, 1'b1, 36, 1'b1,
      '{32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 6'd32, 1'b1}},
    '{32'hA5A5_A5A5, 1'b1, 32, 1'b1,
      '{32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 32'hA5A5_A5A5, 6'd32, 1'b0}},
    '{32'h0000_0011, 1'b0, 32, 1'b0, '0},
    '{32'hFFFF_FFFF, 1'b1, 1,  1'b1, '{32'h11, 32'h11, 32'h11, 32'h11, 6'd32, 1'b1}},
    '{32'h0000_0003, 1'b1, 1,  1'b1, '{32'h3, 32'h3, 32'h3, 32'h3, 6'd1, 1'b0}}
  };

  sorted_sample_percentile_stats_top #(
    .MAX_SAMPLES(MAX_KEPT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #2 clk = ~clk;

  task automatic sort_in_sample(input logic [SAMPLE_W-1:0] v, input bit last,
                                output bit closes, output out_t stats);
    int pos;
    int n;
    closes = last;
    stats = '0;
    if (kept_n >= MAX_KEPT) begin
      dropped = 1'b1;
    end else begin
      pos = kept_n;
      while (pos > 0 && kept[pos-1] > v) begin
        kept[pos] = kept[pos-1];
        pos--;
      end
      kept[pos] = v;
      kept_n++;
    end
    if (last) begin
      n = kept_n;
      stats.min_value = kept[0];
      stats.median_value = kept[n/2];
      stats.p95_value = kept[((n - 1) * 95) / 100];
      stats.max_value = kept[n-1];
      stats.sample_count = SAMPLE_COUNT_W'(n);
      stats.overflowed = dropped;
      sets_closed++;
      if (dropped) overflow_sets++;
      kept_n = 0;
      dropped = 1'b0;
    end
  endtask

  task automatic send(input logic [SAMPLE_W-1:0] v, input bit last, input bit typed,
                      input out_t want);
    bit   closes;
    out_t stats;
    if (!quiet && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.sample_value <= v;
    in_data.is_last <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    sort_in_sample(v, last, closes, stats);
    if (closes) stats_q.push_back(typed ? want : stats);
  endtask

  task automatic send_set(input int size);
    int flavor;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] v;
    flavor = $urandom_range(0, 4);
    base = $urandom;
    for (int i = 0; i < size; i++) begin
      case (flavor)
        0: v = $urandom;
        1: v = base + $urandom_range(0, 3);
        2: v = base + i;
        3: v = base - i;
        default: v = ($urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0) ^
                     (32'($urandom_range(0, 1)) << 31);
      endcase
      send(v, i == size - 1, 1'b0, '0);
    end
  endtask

  task automatic match_field(input string name, input logic [SAMPLE_W-1:0] want,
                             input logic [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (stats_q.size() == 0) begin
        $display("%0t: result transfer with none expected, expected nothing got %h",
                 $time, out_data);
        fails++;
      end else begin
        want = stats_q.pop_front();
        match_field("min_value", want.min_value, out_data.min_value);
        match_field("median_value", want.median_value, out_data.median_value);
        match_field("p95_value", want.p95_value, out_data.p95_value);
        match_field("max_value", want.max_value, out_data.max_value);
        match_field("sample_count", 32'(want.sample_count), 32'(out_data.sample_count));
        match_field("overflowed", 32'(want.overflowed), 32'(out_data.overflowed));
      end
    end
  end

  initial begin
    int hold;
    bit squeezed;
    hold = 0;
    squeezed = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req && !squeezed) begin
        squeezed = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < 15);
      end
    end
  end

  initial begin
    #4_000_000;
    $display("timeout with %0d results outstanding", stats_q.size());
    $display("sorted_sample_percentile_stats_top: mismatch");
    $finish;
  end

  initial begin
    int r;
    int size;
    int set_idx;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int row = 0; row < PLAN_ROWS; row++) begin
      for (int k = 0; k < plan[row].reps; k++) begin
        send(plan[row].value, plan[row].last && k == plan[row].reps - 1,
             plan[row].typed, plan[row].want);
      end
    end

    set_idx = 0;
    while (samples_sent < RANDOM_SAMPLES) begin
      quiet = set_idx >= 40 && set_idx < 70;
      if (set_idx == 20) squeeze_req = 1'b1;
      r = $urandom_range(0, 99);
      if (set_idx >= 20 && set_idx < 28) size = $urandom_range(1, 2);
      else if (r < 70) size = $urandom_range(1, 12);
      else if (r < 90) size = $urandom_range(13, 31);
      else size = $urandom_range(32, 36);
      send_set(size);
      set_idx++;
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (stats_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("%0d samples in %0d sets, %0d results compared", samples_sent, sets_closed,
             results_seen);
    $display("%0d sets overran the %0d-entry store; one %0d-cycle receiver hold-off",
             overflow_sets, MAX_KEPT, HOLD_CYCLES);
    if (fails == 0) begin
      $display("sorted_sample_percentile_stats_top: match");
    end else begin
      $display("sorted_sample_percentile_stats_top: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/sspst_pkg.sv
sv/sorted_sample_percentile_stats_top.sv
sv/sspst_checker.sv
verif/testbench.sv
